// ===== hw/rtl/fts_pkg.sv =====
// Shared types and constants for the fan tach rpm and stall monitor.
package fts_pkg;

	// Field and register widths
	localparam int DUTY_W   = 8;
	localparam int RPM_W    = 16;
	localparam int MS_W     = 16;
	localparam int PULSE_W  = 20;
	localparam int TACH_W   = 2;
	localparam int CMD_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int PER_W    = 8;

	// Arithmetic constants
	localparam int RPM_K_W  = 15;
	localparam logic [RPM_K_W-1:0] RPM_K = RPM_K_W'(30000);  // 60 s * 1000 ms / 2 pulses per rev
	localparam logic [DUTY_W-1:0] RAMP_STEP = DUTY_W'(10);

	localparam int HISTORY_SLOTS_DEF = 8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_DUTY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RAMP     = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_START_DUTY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALL_RPM      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_MS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIXED_PWM_EN   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd6;

	// Register reset values
	localparam logic [DUTY_W-1:0] RST_MIN_START_DUTY = '0;
	localparam logic [RPM_W-1:0]  RST_MAX_RPM        = '1;
	localparam logic [RPM_W-1:0]  RST_STALL_RPM      = '0;
	localparam logic [MS_W-1:0]   RST_INTERVAL_MS    = MS_W'(200);
	localparam logic [MS_W-1:0]   RST_GRACE_MS       = '0;
	localparam logic              RST_FIXED_PWM_EN   = 1'b0;
	localparam logic [PER_W-1:0]  RST_PWM_PERIOD     = '1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_DCHK,
		S_DRUN,
		S_RPM_END,
		S_WIN_SEL,
		S_WIN_END,
		S_FIN
	} fts_state_t;

endpackage

// ===== hw/rtl/fts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fts_ram #(
	parameter int WIDTH  = 36,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/fan_tach_rpm_stall_monitor.sv =====
// Top level of the fan tach rpm and stall monitor: sequencer, shared divider, window store.
//
//  channel | handshake            | word contents
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_stall  | cmd, pulses, duty_request
//  out     | out_valid / out_stall| rpm_updated, rpm, peak_rpm, windowed_rpm,
//          |                      | stall_res, duty_now, pwm_compare
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (ready is always high)
//
// One word at a time. A tick that closes an interval keeps in_stall high through two
// divisions in the one shared divider (interval rpm, then windowed rpm) plus four
// bookkeeping states; every other word runs one division for the windowed rpm, or none
// when the window is empty. Each division runs the divider's 16 quotient steps. in_stall
// is high from acceptance until the result is handed to the output register; that
// register lets the next word in while a result waits. arst_n clears all state but the
// divider datapath and output data registers; the window store needs no clearing (fill count).
module fan_tach_rpm_stall_monitor #(
	parameter int HISTORY_SLOTS = fts_pkg::HISTORY_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fts_pkg::CMD_W-1:0]     cmd,
	input  logic [fts_pkg::TACH_W-1:0]    pulses,
	input  logic [fts_pkg::DUTY_W-1:0]    duty_request,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          rpm_updated,
	output logic [fts_pkg::RPM_W-1:0]     rpm,
	output logic [fts_pkg::RPM_W-1:0]     peak_rpm,
	output logic [fts_pkg::RPM_W-1:0]     windowed_rpm,
	output logic                          stall_res,
	output logic [fts_pkg::DUTY_W-1:0]    duty_now,
	output logic [fts_pkg::DUTY_W-1:0]    pwm_compare,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fts_pkg::CFG_DAT_W-1:0] cfg_data
);

	import fts_pkg::*;

	// Window geometry
	localparam int IDX_W  = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
	localparam int FILL_W = $clog2(HISTORY_SLOTS + 1);
	localparam int PSUM_W = PULSE_W + $clog2(HISTORY_SLOTS);  // pulse sum over window
	localparam int DEN_W  = MS_W + $clog2(HISTORY_SLOTS);     // duration sum over window
	localparam int NUM_W  = PSUM_W + RPM_K_W;                 // pulses * 30000
	localparam int ENT_W  = MS_W + PULSE_W;                   // one window slot
	localparam int QCNT_W = $clog2(RPM_W);

	// Configuration registers
	logic [DUTY_W-1:0] min_duty_q;
	logic [RPM_W-1:0]  max_rpm_q;
	logic [RPM_W-1:0]  stall_rpm_q;
	logic [MS_W-1:0]   interval_q;
	logic [MS_W-1:0]   grace_q;
	logic              fixed_pwm_q;
	logic [PER_W-1:0]  period_q;

	// Architectural state
	logic [DUTY_W-1:0]  duty_q;
	logic [PULSE_W-1:0] pa_q;
	logic [MS_W-1:0]    el_q;
	logic [MS_W-1:0]    spin_q;
	logic [RPM_W-1:0]   last_rpm_q;
	logic [RPM_W-1:0]   peak_q;
	logic [RPM_W-1:0]   wrpm_q;
	logic [IDX_W-1:0]   pos_q;
	logic [FILL_W-1:0]  fill_q;
	logic [PSUM_W-1:0]  psum_q;
	logic [DEN_W-1:0]   dsum_q;

	// Sequencer and divider
	fts_state_t        state_q, state_nx;
	logic              div_win_q;   // 1: window division, 0: interval division
	logic              upd_q;
	logic [NUM_W-1:0]  num_q;       // dividend, low bits shift out as quotient steps run
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [RPM_W-1:0]  quo_q;
	logic              sat_q;       // quotient would not fit 16 bits
	logic [QCNT_W-1:0] cnt_q;

	// Output word register
	logic              out_valid_q;
	logic              o_upd_q;
	logic [RPM_W-1:0]  o_rpm_q;
	logic [RPM_W-1:0]  o_peak_q;
	logic [RPM_W-1:0]  o_wrpm_q;
	logic              o_stall_q;
	logic [DUTY_W-1:0] o_duty_q;
	logic [DUTY_W-1:0] o_cmp_q;

	logic accept;
	logic out_free;
	logic ram_rd_en;

	// ------------------------------------------------------------------
	// Configuration writes
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q  <= RST_MIN_START_DUTY;
			max_rpm_q   <= RST_MAX_RPM;
			stall_rpm_q <= RST_STALL_RPM;
			interval_q  <= RST_INTERVAL_MS;
			grace_q     <= RST_GRACE_MS;
			fixed_pwm_q <= RST_FIXED_PWM_EN;
			period_q    <= RST_PWM_PERIOD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_START_DUTY: min_duty_q  <= cfg_data[DUTY_W-1:0];
				REG_MAX_RPM:        max_rpm_q   <= cfg_data[RPM_W-1:0];
				REG_STALL_RPM:      stall_rpm_q <= cfg_data[RPM_W-1:0];
				REG_INTERVAL_MS:    interval_q  <= cfg_data[MS_W-1:0];
				REG_GRACE_MS:       grace_q     <= cfg_data[MS_W-1:0];
				REG_FIXED_PWM_EN:   fixed_pwm_q <= cfg_data[0];
				REG_PWM_PERIOD:     period_q    <= cfg_data[PER_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Word-level combinational terms
	// ------------------------------------------------------------------
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Tick: saturating counters and interval close
	logic [PULSE_W:0]   pa_sum;
	logic [PULSE_W-1:0] pa_nx;
	logic [MS_W-1:0]    el_nx;
	logic [MS_W-1:0]    spin_inc;
	logic               close;

	assign pa_sum   = {1'b0, pa_q} + (PULSE_W + 1)'(pulses);
	assign pa_nx    = pa_sum[PULSE_W] ? '1 : pa_sum[PULSE_W-1:0];
	assign el_nx    = (el_q == '1) ? el_q : el_q + 1'b1;
	assign spin_inc = (spin_q == '1) ? spin_q : spin_q + 1'b1;
	assign close    = (el_nx >= interval_q);  // el_nx is never zero

	// Duty set and ramp step: dead-start floor, start-from-zero detection
	logic              do_apply;
	logic [DUTY_W-1:0] d_raw;
	logic [DUTY_W-1:0] ramp_nx;
	logic [DUTY_W-1:0] d_fl;
	logic              d_start;

	always_comb begin
		ramp_nx = (duty_q > RAMP_STEP) ? duty_q - RAMP_STEP : '0;
		if (ramp_nx < min_duty_q) begin
			ramp_nx = '0;
		end
		do_apply = 1'b0;
		d_raw    = duty_request;
		case (cmd)
			CMD_SET_DUTY: begin
				do_apply = 1'b1;
			end
			CMD_RAMP: begin
				do_apply = (duty_q != '0);  // ramp at zero duty does nothing
				d_raw    = ramp_nx;
			end
			default: ;
		endcase
		d_fl    = (d_raw != '0 && d_raw < min_duty_q) ? min_duty_q : d_raw;
		d_start = (d_fl != '0) && (duty_q == '0);
	end

	// Shared multiplier: pulses (interval or window) times 30000
	logic [PSUM_W-1:0] mul_a;
	logic [NUM_W-1:0]  mul_p;

	assign mul_a = div_win_q ? psum_q : PSUM_W'(pa_q);
	assign mul_p = NUM_W'(mul_a) * NUM_W'(RPM_K);

	// Shared divider: one restoring step per cycle
	logic [DEN_W:0]   div_t;
	logic             div_ge;
	logic [RPM_W-1:0] div_res;  // clamped quotient

	assign div_t   = {rem_q, num_q[RPM_W-1]};
	assign div_ge  = (div_t >= {1'b0, den_q});
	assign div_res = (sat_q || quo_q > max_rpm_q) ? max_rpm_q : quo_q;

	// Window slot write and the slot being replaced
	logic [ENT_W-1:0] ram_rd_data;
	logic             win_full;
	logic [IDX_W-1:0] pos_nx;
	logic             win_empty;

	assign win_full  = (fill_q == FILL_W'(HISTORY_SLOTS));
	assign pos_nx    = (pos_q == IDX_W'(HISTORY_SLOTS - 1)) ? '0 : pos_q + 1'b1;
	assign win_empty = (fill_q == '0) || (dsum_q == '0);

	// pwm compare: duty * period / 255 when fixed pwm is enabled, else duty; exact for any 8-bit duty and period
	logic [2*DUTY_W-1:0] pwm_prod;
	logic [2*DUTY_W-1:0] pwm_adj;
	logic [DUTY_W-1:0]   pwm_cmp;
	logic                stall_now;

	assign pwm_prod  = (2*DUTY_W)'(duty_q) * (2*DUTY_W)'(period_q);
	assign pwm_adj   = pwm_prod + (2*DUTY_W)'(1) + (pwm_prod >> DUTY_W);
	assign pwm_cmp   = fixed_pwm_q ? pwm_adj[2*DUTY_W-1:DUTY_W] : duty_q;
	assign stall_now = (duty_q != '0) && (spin_q >= grace_q) && (wrpm_q <= stall_rpm_q);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = (cmd == CMD_TICK && close) ? S_MUL : S_WIN_SEL;
				end
			end
			S_MUL:     state_nx = S_DCHK;
			S_DCHK:    state_nx = S_DRUN;
			S_DRUN: begin
				if (cnt_q == QCNT_W'(RPM_W - 1)) begin
					state_nx = div_win_q ? S_WIN_END : S_RPM_END;
				end
			end
			S_RPM_END: state_nx = S_WIN_SEL;
			S_WIN_SEL: state_nx = win_empty ? S_FIN : S_MUL;
			S_WIN_END: state_nx = S_FIN;
			S_FIN: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		ram_rd_en = (state_q == S_IDLE) && in_valid;  // fetch slot about to be replaced
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// ------------------------------------------------------------------
	// State updates
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q     <= '0;
			pa_q       <= '0;
			el_q       <= '0;
			spin_q     <= '0;
			last_rpm_q <= '0;
			peak_q     <= '0;
			wrpm_q     <= '0;
			pos_q      <= '0;
			fill_q     <= '0;
			psum_q     <= '0;
			dsum_q     <= '0;
			div_win_q  <= 1'b0;
			upd_q      <= 1'b0;
			cnt_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						upd_q     <= 1'b0;
						div_win_q <= 1'b0;
						case (cmd) inside
							CMD_TICK: begin
								pa_q   <= pa_nx;
								el_q   <= el_nx;
								spin_q <= spin_inc;
								upd_q  <= close;
							end
							CMD_SET_DUTY, CMD_RAMP: begin
								if (do_apply) begin
									duty_q <= d_fl;
									if (d_start) begin
										// start from standstill: fresh window and peak
										spin_q <= '0;
										pos_q  <= '0;
										fill_q <= '0;
										psum_q <= '0;
										dsum_q <= '0;
										peak_q <= '0;
									end else if (d_fl == '0) begin
										spin_q <= '0;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					cnt_q <= '0;
				end
				S_DRUN: begin
					cnt_q <= cnt_q + 1'b1;
				end
				S_RPM_END: begin
					last_rpm_q <= div_res;
					if (div_res > peak_q) begin
						peak_q <= div_res;
					end
					if (win_full) begin
						psum_q <= psum_q - PSUM_W'(ram_rd_data[PULSE_W-1:0])
							+ PSUM_W'(pa_q);
						dsum_q <= dsum_q - DEN_W'(ram_rd_data[ENT_W-1:PULSE_W])
							+ DEN_W'(el_q);
					end else begin
						fill_q <= fill_q + 1'b1;
						psum_q <= psum_q + PSUM_W'(pa_q);
						dsum_q <= dsum_q + DEN_W'(el_q);
					end
					pos_q <= pos_nx;
					pa_q  <= '0;
					el_q  <= '0;
				end
				S_WIN_SEL: begin
					if (win_empty) begin
						wrpm_q <= last_rpm_q;
					end else begin
						div_win_q <= 1'b1;
					end
				end
				S_WIN_END: begin
					wrpm_q <= div_res;
				end
				default: ;
			endcase
		end
	end

	// Divider datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MUL: begin
				num_q <= mul_p;
				den_q <= div_win_q ? dsum_q : DEN_W'(el_q);
			end
			S_DCHK: begin
				// quotient >= 2^16 always exceeds max_rpm
				sat_q <= (num_q >= NUM_W'({den_q, {RPM_W{1'b0}}}));
				rem_q <= num_q[RPM_W +: DEN_W];
			end
			S_DRUN: begin
				rem_q <= div_ge ? DEN_W'(div_t - {1'b0, den_q}) : div_t[DEN_W-1:0];
				quo_q <= {quo_q[RPM_W-2:0], div_ge};
				num_q <= num_q << 1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Window store: one slot per closed interval, {duration, pulses}
	// ------------------------------------------------------------------
	fts_ram #(
		.WIDTH (ENT_W),
		.DEPTH (HISTORY_SLOTS),
		.ADDR_W(IDX_W)
	) u_win (
		.clk    (clk),
		.wr_en  (state_q == S_RPM_END),
		.wr_addr(pos_q),
		.wr_data({el_q, pa_q}),
		.rd_en  (ram_rd_en),
		.rd_addr(pos_q),
		.rd_data(ram_rd_data)
	);

	// ------------------------------------------------------------------
	// Output word register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			o_upd_q   <= upd_q;
			o_rpm_q   <= last_rpm_q;
			o_peak_q  <= peak_q;
			o_wrpm_q  <= wrpm_q;
			o_stall_q <= stall_now;
			o_duty_q  <= duty_q;
			o_cmp_q   <= pwm_cmp;
		end
	end

	assign out_valid    = out_valid_q;
	assign rpm_updated  = o_upd_q;
	assign rpm          = o_rpm_q;
	assign peak_rpm     = o_peak_q;
	assign windowed_rpm = o_wrpm_q;
	assign stall_res    = o_stall_q;
	assign duty_now     = o_duty_q;
	assign pwm_compare  = o_cmp_q;

endmodule
